@@ sv/rpn_stack_evaluator_unit_macros.svh @@
// Assertion helpers for the RPN evaluator.
`ifndef RPN_STACK_EVALUATOR_UNIT_MACROS_SVH
`define RPN_STACK_EVALUATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RPN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
`define RPN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define RPN_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RPN_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/rpn_pkg.sv @@
`default_nettype none
package rpn_pkg;
  localparam int STACK_DEPTH_DEF = 16;
  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_OP   = 2'd1;
  localparam logic [1:0] REQ_LINE = 2'd2;
  localparam logic [1:0] REQ_EXIT = 2'd3;
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FEW   = 2'd1;
  localparam logic [1:0] ERR_DIV0  = 2'd2;
  localparam logic [1:0] ERR_FULL  = 2'd3;
  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MAG = 64'h8000_0000_0000_0000;

  // stack row control: every cell moves together
  typedef struct packed {
    logic push;     // shift down, load top
    logic pop_wr;   // shift up, load top with result
  } stk_ctl_t;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] apply_sign(input logic neg, input logic [63:0] m,
                                             input logic ovf);
    if (!neg) apply_sign = (ovf || m > POS_MAX) ? POS_MAX : m;
    else if (ovf || m > NEG_MAG) apply_sign = NEG_MAG;
    else apply_sign = ~m + 64'd1;
  endfunction
endpackage
`default_nettype wire

@@ sv/rpn_cell.sv @@
`default_nettype none
// One stack entry: takes its upper neighbor on push, its lower one on pop.
module rpn_cell (
  input  wire logic            clk,
  input  wire rpn_pkg::stk_ctl_t ctl,
  input  wire logic [63:0]     up_val,
  input  wire logic [63:0]     dn_val,
  output logic [63:0]          val
);
  import rpn_pkg::*;
  logic [63:0] val_r;
  always_ff @(posedge clk) begin
    if (ctl.push) val_r <= up_val;
    else if (ctl.pop_wr) val_r <= dn_val;
  end
  assign val = val_r;
endmodule
`default_nettype wire

@@ sv/rpn_alu.sv @@
`default_nettype none
// Add/sub registered straight from the operands, multiply over 4 partial products, divide 1 bit/cycle.
module rpn_alu (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [1:0]  op,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      res
);
  import rpn_pkg::*;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [1:0]  op_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] ma_r, mb_r, res_r, res_nxt;
  logic        neg_r;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] q_r, q_nxt;
  logic        ovf_r, ovf_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [6:0]  msh;
  logic [63:0] sum, dif;
  logic [65:0] trial;
  logic        bit_in;
  logic [6:0]  pos;

  assign sum = a + b;
  assign dif = a - b;
  assign pa  = cnt_r[1] ? ma_r[63:32] : ma_r[31:0];
  assign pb  = cnt_r[0] ? mb_r[63:32] : mb_r[31:0];
  // partial product and its weight: 0, 32 or 64 bits
  assign pp  = {32'd0, pa} * {32'd0, pb};
  assign msh = {{1'b0, cnt_r[1]} + {1'b0, cnt_r[0]}, 5'd0};
  assign pos = 7'd95 - cnt_r;
  assign bit_in = (pos >= 7'd32) ? ma_r[pos[5:0] - 6'd32] : 1'b0;
  // shifted remainder can reach 65 bits; one more bit for the borrow
  assign trial = {1'b0, rem_r[63:0], bit_in} - {2'b00, mb_r};

  always_comb begin
    busy_nxt = busy_r; done_nxt = 1'b0; cnt_nxt = cnt_r; res_nxt = res_r;
    rem_nxt = rem_r; q_nxt = q_r; ovf_nxt = ovf_r; acc_nxt = acc_r;
    if (start) begin
      unique case (op)
        OP_ADD: begin
          done_nxt = 1'b1;
          res_nxt = (~(a[63] ^ b[63]) & (a[63] ^ sum[63])) ? (a[63] ? NEG_MAG : POS_MAX) : sum;
        end
        OP_SUB: begin
          done_nxt = 1'b1;
          res_nxt = ((a[63] ^ b[63]) & (a[63] ^ dif[63])) ? (a[63] ? NEG_MAG : POS_MAX) : dif;
        end
        default: begin
          busy_nxt = 1'b1; cnt_nxt = '0; rem_nxt = '0; q_nxt = '0;
          ovf_nxt = 1'b0; acc_nxt = '0;
        end
      endcase
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 7'd1;
      if (op_r == OP_MUL) begin
        acc_nxt = acc_r + ({64'd0, pp} << msh);
        if (cnt_r == 7'd3) begin
          busy_nxt = 1'b0; done_nxt = 1'b1;
          res_nxt = apply_sign(neg_r, acc_nxt[95:32], acc_nxt[127:96] != 32'd0);
        end
      end else begin
        if (!trial[65]) begin
          rem_nxt = trial[64:0];
          if (pos >= 7'd64) ovf_nxt = 1'b1;
          else q_nxt = q_r | (64'd1 << pos[5:0]);
        end else rem_nxt = {rem_r[63:0], bit_in};
        if (cnt_r == 7'd95) begin
          busy_nxt = 1'b0; done_nxt = 1'b1;
          res_nxt = apply_sign(neg_r, q_nxt, ovf_nxt);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt; res_r <= res_nxt; rem_r <= rem_nxt; q_r <= q_nxt;
    ovf_r <= ovf_nxt; acc_r <= acc_nxt;
    if (start) begin
      op_r <= op; ma_r <= mag64(a); mb_r <= mag64(b); neg_r <= a[63] ^ b[63];
    end
  end
  assign done = done_r;
  assign res  = res_r;
endmodule
`default_nettype wire

@@ sv/rpn_stack_evaluator_unit.sv @@
`default_nettype none
// RPN evaluator over a shift-register stack of cells (top in cell 0).
// Add/sub, multiply and divide run in the ALU.
// Divide runs one quotient bit per cycle in the ALU divider.
// One item at a time; output register holds a result until taken.
// rst_n synchronous active low clears count, halt and control; stack data is not reset.
module rpn_stack_evaluator_unit #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // operand_value[63:0], op_code[65:64], zero pad
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // result_value[63:0], stack_empty[64], error_code[66:65]
  output logic [1:0]       out_tuser   // unused kind, zero
);
  import rpn_pkg::*;
  `include "rpn_stack_evaluator_unit_macros.svh"
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ALU  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        halt_r, halt_nxt;
  logic        ov_r, ov_nxt;
  logic [66:0] od_r, od_nxt;
  stk_ctl_t    ctl;
  logic        alu_start, alu_done;
  logic [63:0] alu_res, top_in;
  logic [63:0] cv [STACK_DEPTH];
  logic        acc;

  // stack row
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    rpn_cell u_cell (.clk(clk), .ctl(ctl),
      .up_val(i == 0 ? top_in : cv[i == 0 ? 0 : i-1]),
      .dn_val(i == 0 ? alu_res : cv[i == STACK_DEPTH-1 ? i : i+1]), .val(cv[i]));
  end

  rpn_alu u_alu (.clk(clk), .rst_n(rst_n), .start(alu_start), .op(in_tdata[65:64]),
    .a(cv[1]), .b(cv[0]), .done(alu_done), .res(alu_res));

  assign in_tready = (state_r == S_IDLE) && !ov_r;
  assign acc = in_tvalid && in_tready;
  assign top_in = in_tdata[63:0];

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; halt_nxt = halt_r;
    ov_nxt = ov_r && !out_tready; od_nxt = od_r;
    ctl = '0; alu_start = 1'b0;
    unique case (state_r)
      S_IDLE: if (acc && !halt_r) begin
        unique case (in_tuser)
          REQ_PUSH: if (cnt_r >= CW'(STACK_DEPTH)) begin
            halt_nxt = 1'b1; ov_nxt = 1'b1; od_nxt = {ERR_FULL, 1'b0, 64'd0};
          end else begin
            ctl.push = 1'b1; cnt_nxt = cnt_r + CW'(1);
          end
          REQ_OP: if (cnt_r < CW'(2)) begin
            halt_nxt = 1'b1; ov_nxt = 1'b1; od_nxt = {ERR_FEW, 1'b0, 64'd0};
          end else if (in_tdata[65:64] == OP_DIV && cv[0] == 64'd0) begin
            halt_nxt = 1'b1; ov_nxt = 1'b1; od_nxt = {ERR_DIV0, 1'b0, 64'd0};
          end else begin
            alu_start = 1'b1; state_nxt = S_ALU;
          end
          REQ_LINE: begin
            ov_nxt = 1'b1;
            od_nxt = (cnt_r == '0) ? {ERR_NONE, 1'b1, 64'd0} : {ERR_NONE, 1'b0, cv[0]};
          end
          default: halt_nxt = 1'b1;
        endcase
      end
      S_ALU: if (alu_done) begin
        ctl.pop_wr = 1'b1; cnt_nxt = cnt_r - CW'(1); state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; halt_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; halt_r <= halt_nxt; ov_r <= ov_nxt;
    end
    od_r <= od_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, od_r};
  assign out_tuser  = 2'd0;

  `RPN_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CW'(STACK_DEPTH))
  `RPN_ASSERT_NXT(a_halt_sticky, clk, rst_n, halt_r, halt_r)
  `RPN_ASSERT_IMP(a_no_acc_busy, clk, rst_n, state_r == S_ALU, !in_tready)
  `RPN_ASSERT_NXT(a_start_alu, clk, rst_n, alu_start, state_r == S_ALU)
endmodule
`default_nettype wire
